>>> rtl/core/hbsf_pkg.sv
// Shared constants and helper functions of the header block substring filter.
package hbsf_pkg;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_CASE_FOLD   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_W0  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_W1  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_W2  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_W3  = 3'd5;

	localparam int CFG_DATA_W    = 64;
	localparam int PAT_WORDS     = 4;
	localparam int PAT_LEN_W     = 6;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_NUL     = 8'h00;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] line_pos_t;

	// Expected byte at each of the four places of the record header "BSS ".
	function automatic byte_t header_char(input logic [1:0] pos);
		byte_t ch;
		case (pos)
			2'd0: ch = 8'h42;
			2'd1: ch = 8'h53;
			2'd2: ch = 8'h53;
			2'd3: ch = 8'h20;
			default: ch = 8'h20;
		endcase
		return ch;
	endfunction

	// ASCII lower-case folding, applied only when case is ignored.
	function automatic byte_t fold(input byte_t ch, input logic fold_en);
		byte_t res;
		res = ch;
		if (fold_en && (ch inside {[8'h41:8'h5A]})) begin
			res = ch + 8'd32;
		end
		return res;
	endfunction

endpackage

>>> rtl/core/hbsf_ifs.sv
// Channel interfaces of the header block substring filter: text in, results out, configuration.
interface hbsf_byte_if;
	logic              valid;
	logic              ready;
	hbsf_pkg::byte_t   data_byte;
	logic              stream_end;

	modport source (output valid, output data_byte, output stream_end, input ready);
	modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface hbsf_result_if #(
	parameter int LENGTH_BITS = 20
);
	logic                   valid;
	logic                   ready;
	logic                   record_kept;
	logic [LENGTH_BITS-1:0] record_length;
	logic                   separator_needed;
	logic                   final_result;
	logic                   any_record_kept;

	modport source (output valid, output record_kept, output record_length,
		output separator_needed, output final_result, output any_record_kept, input ready);
	modport sink   (input valid, input record_kept, input record_length,
		input separator_needed, input final_result, input any_record_kept, output ready);
endinterface

interface hbsf_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [hbsf_pkg::CFG_INDEX_W-1:0]       index;
	logic [hbsf_pkg::CFG_DATA_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/header_block_substring_filter.sv
// Top level of the header block substring filter: record splitting, shift-and search, result queue.
//
// The block takes a text stream one byte per beat and splits it into lines ending in a newline.
// A line starting with "BSS " opens a record; bytes ahead of the first such line belong to no
// record. Every line is searched for the configured pattern (up to PATTERN_MAX bytes, optional
// ASCII case folding) with a shift-and match vector that is cleared at each line start; a NUL
// byte hides the rest of its line from both matching and counting, and an empty pattern matches
// any line with at least one byte. Each time a header is confirmed, at its fourth byte, and on
// the stream_end beat, one result beat describes the record that has just closed: keep decision,
// saturating byte length, separator flag and running any-kept flag. The stream_end beat returns
// all record state to its reset value while the configuration registers keep their contents.
// Rate: one byte beat per clock cycle while input is not stalled. An accepted beat is registered
// in the input stage, the whole per-byte update (header compare, PATTERN_MAX parallel byte
// compares, shift-and step and length adders) runs in the following cycle, and a result is
// written into a four-entry result queue whose head drives the output. The queue lets input
// continue while results wait; input stalls only when the queue plus the input stage would hold
// more than four beats. No clearing pass follows reset. Configuration writes are always accepted
// and must only be made while the block is idle.
module header_block_substring_filter #(
	parameter int PATTERN_MAX = 32,
	parameter int LENGTH_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	hbsf_byte_if.sink                                text_in,
	hbsf_result_if.source                            result_out,
	hbsf_cfg_if.sink                                 cfg
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam int RES_W       = LENGTH_BITS + 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration registers.
	logic                                                   case_fold_q;
	logic [hbsf_pkg::PAT_LEN_W-1:0]                         pattern_len_q;
	logic [hbsf_pkg::PAT_WORDS-1:0][hbsf_pkg::CFG_DATA_W-1:0] pattern_q;

	// Input stage.
	logic            valid_s1;
	hbsf_pkg::byte_t data_s1;
	logic            end_s1;

	// Record and line state.
	logic                   active_q;
	logic                   matched_q;
	logic                   line_hit_q;
	hbsf_pkg::line_pos_t    pos_q;
	logic                   prefix_ok_q;
	logic                   after_nul_q;
	logic [PATTERN_MAX-1:0] pmv_q;
	logic [LENGTH_BITS-1:0] len_before_q;
	logic [LENGTH_BITS-1:0] len_line_q;
	logic                   kept_so_far_q;

	logic                   active_n;
	logic                   matched_n;
	logic                   line_hit_n;
	hbsf_pkg::line_pos_t    pos_n;
	logic                   prefix_ok_n;
	logic                   after_nul_n;
	logic [PATTERN_MAX-1:0] pmv_n;
	logic [LENGTH_BITS-1:0] len_before_n;
	logic [LENGTH_BITS-1:0] len_line_n;
	logic                   kept_so_far_n;

	// Result produced in this cycle.
	logic                   emit;
	logic [RES_W-1:0]       res_word;

	// Result queue.
	logic [RES_W-1:0]       queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]      wr_ptr_q;
	logic [QPTR_W-1:0]      rd_ptr_q;
	logic [QPTR_W:0]        count_q;
	logic                   push;
	logic                   pop;

	// Matching helpers.
	logic [hbsf_pkg::PAT_LEN_W-1:0] used_len;
	hbsf_pkg::byte_t                folded_char;
	logic [PATTERN_MAX-1:0]         match_bits;
	logic [PATTERN_MAX-1:0]         last_mask;
	logic [PATTERN_MAX-1:0]         pmv_step;
	logic [LENGTH_BITS:0]           commit_sum;
	logic [LENGTH_BITS-1:0]         commit_len;

	// ------------------------------------------------------------------
	// Configuration port: always ready, writes beyond the list are dropped.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_fold_q   <= 1'b0;
			pattern_len_q <= '0;
			pattern_q     <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				hbsf_pkg::CFG_CASE_FOLD:   case_fold_q   <= cfg.data[0];
				hbsf_pkg::CFG_PATTERN_LEN: pattern_len_q <= cfg.data[hbsf_pkg::PAT_LEN_W-1:0];
				hbsf_pkg::CFG_PATTERN_W0:  pattern_q[0]  <= cfg.data;
				hbsf_pkg::CFG_PATTERN_W1:  pattern_q[1]  <= cfg.data;
				hbsf_pkg::CFG_PATTERN_W2:  pattern_q[2]  <= cfg.data;
				hbsf_pkg::CFG_PATTERN_W3:  pattern_q[3]  <= cfg.data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input stage. Ready is held back only when the result queue, counting
	// the beat already in the input stage, could overflow.
	// ------------------------------------------------------------------
	assign text_in.ready = ((QPTR_W+2)'(count_q) + (QPTR_W+2)'(valid_s1))
		< (QPTR_W+2)'(QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= text_in.valid && text_in.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			data_s1 <= text_in.data_byte;
			end_s1  <= text_in.stream_end;
		end
	end

	// ------------------------------------------------------------------
	// Shift-and match: one compare per pattern place, all in parallel.
	// ------------------------------------------------------------------
	assign used_len = (pattern_len_q > hbsf_pkg::PAT_LEN_W'(PATTERN_MAX))
		? hbsf_pkg::PAT_LEN_W'(PATTERN_MAX) : pattern_len_q;
	assign folded_char = hbsf_pkg::fold(data_s1, case_fold_q);

	for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_place
		assign match_bits[g] = (hbsf_pkg::PAT_LEN_W'(g) < used_len)
			&& (hbsf_pkg::fold(pattern_q[g/8][(g%8)*8 +: 8], case_fold_q) == folded_char);
		assign last_mask[g]  = (used_len == hbsf_pkg::PAT_LEN_W'(g + 1));
	end

	if (PATTERN_MAX > 1) begin : g_shift_wide
		assign pmv_step = {pmv_q[PATTERN_MAX-2:0], 1'b1} & match_bits;
	end else begin : g_shift_one
		assign pmv_step = match_bits;
	end

	// ------------------------------------------------------------------
	// Per-byte state update. Line commit folds the line's length and hit
	// into the open record; header confirmation and stream_end emit the closed record.
	// ------------------------------------------------------------------
	always_comb begin
		active_n      = active_q;
		matched_n     = matched_q;
		line_hit_n    = line_hit_q;
		pos_n         = pos_q;
		prefix_ok_n   = prefix_ok_q;
		after_nul_n   = after_nul_q;
		pmv_n         = pmv_q;
		len_before_n  = len_before_q;
		len_line_n    = len_line_q;
		kept_so_far_n = kept_so_far_q;
		emit          = 1'b0;
		res_word      = '0;
		commit_sum    = '0;
		commit_len    = '0;

		if (valid_s1) begin
			if (end_s1) begin
				// Close the unterminated last line, then report and restart.
				if (pos_q != '0 && active_q) begin
					commit_sum = {1'b0, len_before_q} + {1'b0, len_line_q};
					len_before_n = (commit_sum > {1'b0, LEN_MAX}) ? LEN_MAX
						: commit_sum[LENGTH_BITS-1:0];
					matched_n = matched_q || line_hit_q;
				end
				emit = 1'b1;
				res_word = {active_n && matched_n,
					active_n ? len_before_n : {LENGTH_BITS{1'b0}},
					active_n && matched_n && kept_so_far_q,
					1'b1,
					kept_so_far_q || (active_n && matched_n)};
				active_n      = 1'b0;
				matched_n     = 1'b0;
				len_before_n  = '0;
				kept_so_far_n = 1'b0;
				line_hit_n    = 1'b0;
				pos_n         = '0;
				prefix_ok_n   = 1'b1;
				after_nul_n   = 1'b0;
				pmv_n         = '0;
				len_line_n    = '0;
			end else begin
				if (used_len == '0) begin
					line_hit_n = 1'b1;
				end
				if (!after_nul_q) begin
					if (!pos_q[2]) begin
						if (data_s1 != hbsf_pkg::header_char(pos_q[1:0])) begin
							prefix_ok_n = 1'b0;
						end else if (pos_q == 3'd3 && prefix_ok_q) begin
							emit = 1'b1;
							res_word = {active_q && matched_q,
								active_q ? len_before_q : {LENGTH_BITS{1'b0}},
								active_q && matched_q && kept_so_far_q,
								1'b0,
								kept_so_far_q || (active_q && matched_q)};
							kept_so_far_n = kept_so_far_q || (active_q && matched_q);
							active_n      = 1'b1;
							matched_n     = 1'b0;
							len_before_n  = '0;
						end
					end
					if (data_s1 == hbsf_pkg::CHAR_NUL) begin
						after_nul_n = 1'b1;
					end else begin
						len_line_n = (len_line_q == LEN_MAX) ? LEN_MAX
							: len_line_q + LENGTH_BITS'(1);
						if (used_len != '0) begin
							pmv_n = pmv_step;
							if ((pmv_step & last_mask) != '0) begin
								line_hit_n = 1'b1;
							end
						end
					end
				end
				if (pos_q != 3'd7) begin
					pos_n = pos_q + 3'd1;
				end
				if (data_s1 == hbsf_pkg::CHAR_NEWLINE) begin
					if (active_n) begin
						commit_sum = {1'b0, len_before_n} + {1'b0, len_line_n};
						commit_len = (commit_sum > {1'b0, LEN_MAX}) ? LEN_MAX
							: commit_sum[LENGTH_BITS-1:0];
						len_before_n = commit_len;
						matched_n = matched_n || line_hit_n;
					end
					line_hit_n  = 1'b0;
					pos_n       = '0;
					prefix_ok_n = 1'b1;
					after_nul_n = 1'b0;
					pmv_n       = '0;
					len_line_n  = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			matched_q     <= 1'b0;
			line_hit_q    <= 1'b0;
			pos_q         <= '0;
			prefix_ok_q   <= 1'b1;
			after_nul_q   <= 1'b0;
			pmv_q         <= '0;
			len_before_q  <= '0;
			len_line_q    <= '0;
			kept_so_far_q <= 1'b0;
		end else begin
			active_q      <= active_n;
			matched_q     <= matched_n;
			line_hit_q    <= line_hit_n;
			pos_q         <= pos_n;
			prefix_ok_q   <= prefix_ok_n;
			after_nul_q   <= after_nul_n;
			pmv_q         <= pmv_n;
			len_before_q  <= len_before_n;
			len_line_q    <= len_line_n;
			kept_so_far_q <= kept_so_far_n;
		end
	end

	// ------------------------------------------------------------------
	// Result queue. Its head drives the output channel directly.
	// ------------------------------------------------------------------
	assign push = emit;
	assign pop  = result_out.valid && result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= res_word;
		end
	end

	assign result_out.valid            = (count_q != '0);
	assign result_out.record_kept      = queue_q[rd_ptr_q][RES_W-1];
	assign result_out.record_length    = queue_q[rd_ptr_q][RES_W-2 -: LENGTH_BITS];
	assign result_out.separator_needed = queue_q[rd_ptr_q][2];
	assign result_out.final_result     = queue_q[rd_ptr_q][1];
	assign result_out.any_record_kept  = queue_q[rd_ptr_q][0];

endmodule

>>> rtl/core/hbsf_checker.sv
// Port-level checker of the header block substring filter and its bind statement.
module hbsf_checker #(
	parameter int LENGTH_BITS = 20
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   record_kept,
	input logic [LENGTH_BITS-1:0] record_length,
	input logic                   separator_needed,
	input logic                   final_result,
	input logic                   any_record_kept
);

	// A waiting result beat keeps its contents until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(record_kept)
			&& $stable(record_length) && $stable(separator_needed)
			&& $stable(final_result) && $stable(any_record_kept))
		else $error("result beat changed while stalled");

	// A separator is only asked for between two kept records.
	a_sep_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && separator_needed |-> record_kept)
		else $error("separator without a kept record");

	// The running flag covers the record reported in the same beat.
	a_any_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kept |-> any_record_kept)
		else $error("kept record not reflected in any_record_kept");

	// A kept record holds at least its four header bytes.
	a_kept_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kept |-> record_length >= LENGTH_BITS'(4))
		else $error("kept record shorter than its header");

endmodule

bind header_block_substring_filter hbsf_checker #(
	.LENGTH_BITS (LENGTH_BITS)
) u_hbsf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (result_out.valid),
	.out_ready        (result_out.ready),
	.record_kept      (result_out.record_kept),
	.record_length    (result_out.record_length),
	.separator_needed (result_out.separator_needed),
	.final_result     (result_out.final_result),
	.any_record_kept  (result_out.any_record_kept)
);
